// ----- src/bnpm_pkg.sv -----
// shared types and constants of the bus node poll master
package bnpm_pkg;

	localparam int NODES  = 8;
	localparam int NODE_W = 3;

	localparam logic [2:0]  LAST_PART        = 3'd5;
	localparam logic [1:0]  FAIL_LIMIT       = 2'd3;
	localparam logic [3:0]  ALL_STATUS_PARTS = 4'hF;
	localparam logic [22:0] CFG_OFF_ID       = 23'd1;
	localparam logic [3:0]  LEN_PARAM        = 4'd8;
	localparam logic [3:0]  LEN_POLL         = 4'd1;

	typedef enum logic [2:0] {
		REG_CMD_SET_PARAM     = 3'd0,
		REG_CMD_SET_PARAM_ACK = 3'd1,
		REG_CMD_STATUS_POLL   = 3'd2,
		REG_CMD_STATUS_ACK    = 3'd3,
		REG_TICK_PRESCALE     = 3'd4,
		REG_MAX_RETRIES       = 3'd5,
		REG_REPLY_TIMEOUT     = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		PH_INIT    = 3'd0,
		PH_LOAD    = 3'd1,
		PH_SEND    = 3'd2,
		PH_WAIT    = 3'd3,
		PH_TIMEOUT = 3'd4,
		PH_PARSE   = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		RF_NONE    = 2'd0,
		RF_TIMEOUT = 2'd1,
		RF_DONE    = 2'd2
	} reply_flag_t;

	typedef struct packed {
		logic [7:0] cmd_set_param;
		logic [7:0] cmd_set_param_ack;
		logic [7:0] cmd_status_poll;
		logic [7:0] cmd_status_ack;
		logic [7:0] tick_prescale;
		logic [7:0] max_retries;
		logic [7:0] reply_timeout;
	} cfg_t;

	typedef struct packed {
		logic        command;
		logic [22:0] rx_ext_id;
		logic [7:0]  rx_data0;
	} req_t;

	typedef struct packed {
		logic        tx_valid;
		logic [18:0] tx_ext_id;
		logic [3:0]  tx_length;
		logic        tx_is_param;
		logic [2:0]  tx_param_part;
		logic [7:0]  node_fail_mask;
	} rsp_t;

endpackage

// ----- src/bnpm_cfg_regs.sv -----
// configuration register bank of the poll master
module bnpm_cfg_regs
	import bnpm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	output cfg_t       cfg
);

	cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cmd_set_param     <= 8'd1;
			cfg_q.cmd_set_param_ack <= 8'd2;
			cfg_q.cmd_status_poll   <= 8'd3;
			cfg_q.cmd_status_ack    <= 8'd4;
			cfg_q.tick_prescale     <= 8'd1;
			cfg_q.max_retries       <= 8'd3;
			cfg_q.reply_timeout     <= 8'd200;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CMD_SET_PARAM:     cfg_q.cmd_set_param     <= cfg_data;
				REG_CMD_SET_PARAM_ACK: cfg_q.cmd_set_param_ack <= cfg_data;
				REG_CMD_STATUS_POLL:   cfg_q.cmd_status_poll   <= cfg_data;
				REG_CMD_STATUS_ACK:    cfg_q.cmd_status_ack    <= cfg_data;
				REG_TICK_PRESCALE:     cfg_q.tick_prescale     <= cfg_data;
				REG_MAX_RETRIES:       cfg_q.max_retries       <= cfg_data;
				REG_REPLY_TIMEOUT:     cfg_q.reply_timeout     <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- src/bnpm_ctrl.sv -----
// polling state machine, per node bookkeeping and result formation
module bnpm_ctrl
	import bnpm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step,
	input  req_t req,
	input  cfg_t cfg,
	output rsp_t rsp
);

	phase_t                  phase_q, phase_d;
	logic [NODE_W-1:0]       node_q, node_d;
	logic [2:0]              part_q, part_d;
	logic [7:0]              retries_q, retries_d;
	logic [7:0]              wait_q, wait_d;
	reply_flag_t             reply_q, reply_d;
	logic                    final_q, final_d;
	logic                    sending_q, sending_d;
	logic [7:0]              prescale_q, prescale_d;
	logic [NODES-1:0]        data_req_q, data_req_d;
	logic [NODES-1:0][3:0]   status_q, status_d;
	logic [NODES-1:0][1:0]   fail_cnt_q, fail_cnt_d;
	logic [NODES-1:0]        fail_flag_q, fail_flag_d;

	logic [6:0]              rx_part;
	logic [7:0]              rx_cmd;
	logic [7:0]              rx_ads;
	logic [7:0]              rx_ads_m1;
	logic [NODE_W-1:0]       rx_node;
	logic                    rx_ok;
	logic [NODE_W:0]         nn_sum;
	logic [NODE_W-1:0]       node_next;
	logic [7:0]              pc_inc;
	logic [7:0]              node_addr;

	assign rx_part   = req.rx_ext_id[22:16];
	assign rx_cmd    = req.rx_ext_id[15:8];
	assign rx_ads    = req.rx_ext_id[7:0];
	assign rx_ads_m1 = rx_ads - 8'd1;
	assign rx_node   = rx_ads_m1[NODE_W-1:0];
	assign rx_ok     = (req.rx_ext_id != CFG_OFF_ID) && (rx_ads != 8'd0)
		&& (rx_ads <= 8'(NODES));
	assign nn_sum    = {1'b0, node_q} + (NODE_W + 1)'(1);
	assign node_next = (nn_sum >= (NODE_W + 1)'(NODES)) ? '0 : nn_sum[NODE_W-1:0];
	assign pc_inc    = prescale_q + 8'd1;
	assign node_addr = 8'(node_q) + 8'd1;

	always_comb begin
		logic [3:0] sp;
		logic [7:0] wc;
		phase_d     = phase_q;
		node_d      = node_q;
		part_d      = part_q;
		retries_d   = retries_q;
		wait_d      = wait_q;
		reply_d     = reply_q;
		final_d     = final_q;
		sending_d   = sending_q;
		prescale_d  = prescale_q;
		data_req_d  = data_req_q;
		status_d    = status_q;
		fail_cnt_d  = fail_cnt_q;
		fail_flag_d = fail_flag_q;
		rsp         = '0;
		sp          = status_q[rx_node];
		wc          = wait_q;

		if (req.command) begin
			// received frame
			if (rx_ok) begin
				if (rx_cmd == cfg.cmd_set_param_ack) begin
					if (phase_q == PH_WAIT)
						reply_d = RF_DONE;
				end else if (rx_cmd == cfg.cmd_status_ack) begin
					if (rx_part <= 7'd3)
						sp = sp | (4'b0001 << rx_part[1:0]);
					status_d[rx_node] = sp;
					if (rx_part == 7'd2)
						data_req_d[rx_node] = (req.rx_data0 != 8'd0);
					if (sp == ALL_STATUS_PARTS && phase_q == PH_WAIT)
						reply_d = RF_DONE;
				end
			end
		end else if (pc_inc >= cfg.tick_prescale) begin
			prescale_d = '0;
			unique case (phase_q)
				PH_INIT: begin
					node_d    = '0;
					part_d    = '0;
					retries_d = cfg.max_retries;
					phase_d   = PH_LOAD;
				end
				PH_WAIT: begin
					if (wc != 8'd0)
						wc = wc - 8'd1;
					wait_d = wc;
					if (wc == 8'd0)
						phase_d = PH_TIMEOUT;
					if (reply_q == RF_TIMEOUT)
						phase_d = PH_TIMEOUT;
					else if (reply_q == RF_DONE)
						phase_d = PH_PARSE;
				end
				PH_LOAD: begin
					reply_d = RF_NONE;
					if (data_req_q[node_q]) begin
						sending_d = 1'b1;
						final_d   = (part_q == LAST_PART);
					end else begin
						sending_d        = 1'b0;
						final_d          = 1'b1;
						status_d[node_q] = '0;
					end
					phase_d = PH_SEND;
				end
				PH_SEND: begin
					rsp.tx_valid = 1'b1;
					if (sending_q) begin
						rsp.tx_ext_id     = {part_q, cfg.cmd_set_param, node_addr};
						rsp.tx_length     = LEN_PARAM;
						rsp.tx_is_param   = 1'b1;
						rsp.tx_param_part = part_q;
					end else begin
						rsp.tx_ext_id = {part_q, cfg.cmd_status_poll, node_addr};
						rsp.tx_length = LEN_POLL;
					end
					if (final_q) begin
						wait_d  = cfg.reply_timeout;
						phase_d = PH_WAIT;
					end else begin
						part_d  = part_q + 3'd1;
						phase_d = PH_LOAD;
					end
				end
				PH_TIMEOUT: begin
					if (retries_q > 8'd1) begin
						retries_d = retries_q - 8'd1;
						if (final_q)
							part_d = '0;
						phase_d = PH_LOAD;
					end else begin
						if (fail_cnt_q[node_q] < FAIL_LIMIT)
							fail_cnt_d[node_q] = fail_cnt_q[node_q] + 2'd1;
						else
							fail_flag_d[node_q] = 1'b1;
						node_d    = node_next;
						part_d    = '0;
						retries_d = cfg.max_retries;
						phase_d   = PH_LOAD;
					end
				end
				PH_PARSE: begin
					fail_cnt_d[node_q] = '0;
					if (sending_q)
						data_req_d[node_q] = 1'b0;
					node_d    = node_next;
					part_d    = '0;
					retries_d = cfg.max_retries;
					phase_d   = PH_LOAD;
				end
				default: phase_d = PH_INIT;
			endcase
		end else begin
			prescale_d = pc_inc;
		end

		rsp.node_fail_mask = 8'(fail_flag_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_INIT;
			node_q      <= '0;
			part_q      <= '0;
			retries_q   <= '0;
			wait_q      <= '0;
			reply_q     <= RF_NONE;
			final_q     <= 1'b0;
			sending_q   <= 1'b0;
			prescale_q  <= '0;
			data_req_q  <= '0;
			status_q    <= '0;
			fail_cnt_q  <= '0;
			fail_flag_q <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			node_q      <= node_d;
			part_q      <= part_d;
			retries_q   <= retries_d;
			wait_q      <= wait_d;
			reply_q     <= reply_d;
			final_q     <= final_d;
			sending_q   <= sending_d;
			prescale_q  <= prescale_d;
			data_req_q  <= data_req_d;
			status_q    <= status_d;
			fail_cnt_q  <= fail_cnt_d;
			fail_flag_q <= fail_flag_d;
		end
	end

endmodule

// ----- src/bnpm_out_reg.sv -----
// result register with valid and ready toward the consumer
module bnpm_out_reg
	import bnpm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  rsp_t rsp_in,
	output logic free,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp_data
);

	logic valid_q;
	rsp_t data_q;

	assign free      = !valid_q || rsp_ready;
	assign rsp_valid = valid_q;
	assign rsp_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (rsp_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			data_q <= rsp_in;
	end

endmodule

// ----- src/bus_node_poll_master_unit.sv -----
// top level of the bus node poll master
// a request waits in the input register until the result register is free,
// then its result is loaded there and rsp_valid rises; throughput: one request
// per cycle while the output is free, set by the single state update per step
// reset: arst_n clears the control state, the per node tables and the
// configuration registers to their defaults; requests are taken right after
module bus_node_poll_master_unit
	import bnpm_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_ready,
	input  req_t       req_data,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output rsp_t       rsp_data,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	logic valid_s1;
	req_t req_s1;
	logic out_free;
	logic advance;
	cfg_t cfg;
	rsp_t rsp_c;

	assign advance   = valid_s1 && out_free;
	assign req_ready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready)
			req_s1 <= req_data;
	end

	bnpm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bnpm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.req    (req_s1),
		.cfg    (cfg),
		.rsp    (rsp_c)
	);

	bnpm_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (advance),
		.rsp_in    (rsp_c),
		.free      (out_free),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data)
	);

endmodule

// ----- src/bnpm_checker.sv -----
// port level checks of the poll master and their binding
module bnpm_checker
	import bnpm_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp_data
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
		else $error("result changed while stalled");

	// no frame means empty frame fields
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_data.tx_valid |-> rsp_data.tx_ext_id == '0
		&& rsp_data.tx_length == '0 && !rsp_data.tx_is_param
		&& rsp_data.tx_param_part == '0)
		else $error("idle step carries frame fields");

	// frame kind and length agree
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.tx_valid |->
		(rsp_data.tx_is_param && rsp_data.tx_length == LEN_PARAM
		&& rsp_data.tx_param_part == rsp_data.tx_ext_id[18:16])
		|| (!rsp_data.tx_is_param && rsp_data.tx_length == LEN_POLL
		&& rsp_data.tx_param_part == '0))
		else $error("frame kind and length disagree");

	// sent frames address a real node
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.tx_valid |->
		rsp_data.tx_ext_id[7:0] != 8'd0 && rsp_data.tx_ext_id[7:0] <= 8'(NODES))
		else $error("frame addressed to no node");

endmodule

bind bus_node_poll_master_unit bnpm_checker u_bnpm_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.rsp_valid (rsp_valid),
	.rsp_ready (rsp_ready),
	.rsp_data  (rsp_data)
);

// ----- dv/bus_node_poll_master_unit_tb.sv -----
// self-checking testbench for the bus node poll master unit
module bus_node_poll_master_unit_tb;
	import bnpm_pkg::*;

	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_FRAME = 1'b1;
	localparam int   CYCLE_LIMIT = 200000;

	typedef struct packed {
		cfg_t             cfg;
		phase_t           ph;
		logic [2:0]       node;
		logic [2:0]       part;
		logic [7:0]       retries;
		logic [7:0]       wait_cnt;
		logic [7:0]       prescale;
		reply_flag_t      rflag;
		logic             final_frm;
		logic             sending;
		logic [7:0]       data_req;
		logic [7:0][3:0]  parts;
		logic [7:0][1:0]  fails;
		logic [7:0]       flags;
	} poll_state_t;

	logic       clk;
	logic       arst_n;
	logic       req_valid;
	logic       req_ready;
	req_t       req_data;
	logic       rsp_valid;
	logic       rsp_ready;
	rsp_t       rsp_data;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [2:0] cfg_index;
	logic [7:0] cfg_data;

	poll_state_t pred_st;
	poll_state_t plan_st;
	req_t        req_backlog[$];
	rsp_t        frame_expect[$];
	rsp_t        want;
	logic        req_took = 1'b0;
	bit          calm;
	int          req_gap = 0;
	int          rsp_stall = 0;
	int          queued = 0;
	int          errors = 0;
	int          shown = 0;
	int          cycles = 0;

	bus_node_poll_master_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// one request through the polling machine, returns the frame it sends
	function automatic void poll_step(inout poll_state_t s, input req_t r, output rsp_t o);
		logic [6:0] prt;
		logic [7:0] code;
		logic [7:0] ads;
		logic [2:0] n;
		logic       advance;
		o = '0;
		advance = 1'b0;
		prt = r.rx_ext_id[22:16];
		code = r.rx_ext_id[15:8];
		ads = r.rx_ext_id[7:0];
		if (r.command == CMD_FRAME) begin
			if (r.rx_ext_id != CFG_OFF_ID && ads >= 8'd1 && ads <= 8'(NODES)) begin
				n = 3'(ads - 8'd1);
				if (code == s.cfg.cmd_set_param_ack) begin
					if (s.ph == PH_WAIT)
						s.rflag = RF_DONE;
				end else if (code == s.cfg.cmd_status_ack) begin
					if (prt <= 7'd3)
						s.parts[n][prt[1:0]] = 1'b1;
					if (prt == 7'd2)
						s.data_req[n] = (r.rx_data0 != 8'd0);
					if (s.parts[n] == ALL_STATUS_PARTS && s.ph == PH_WAIT)
						s.rflag = RF_DONE;
				end
			end
		end else begin
			s.prescale = s.prescale + 8'd1;
			if (s.prescale >= s.cfg.tick_prescale) begin
				s.prescale = '0;
				n = s.node;
				case (s.ph)
				PH_INIT: begin
					s.node = '0;
					s.part = '0;
					s.retries = s.cfg.max_retries;
					s.ph = PH_LOAD;
				end
				PH_WAIT: begin
					if (s.wait_cnt != 8'd0)
						s.wait_cnt = s.wait_cnt - 8'd1;
					if (s.wait_cnt == 8'd0)
						s.ph = PH_TIMEOUT;
					if (s.rflag == RF_TIMEOUT)
						s.ph = PH_TIMEOUT;
					else if (s.rflag == RF_DONE)
						s.ph = PH_PARSE;
				end
				PH_LOAD: begin
					s.rflag = RF_NONE;
					if (s.data_req[n]) begin
						s.sending = 1'b1;
						s.final_frm = (s.part == LAST_PART);
					end else begin
						s.sending = 1'b0;
						s.final_frm = 1'b1;
						s.parts[n] = '0;
					end
					s.ph = PH_SEND;
				end
				PH_SEND: begin
					o.tx_valid = 1'b1;
					if (s.sending) begin
						o.tx_ext_id = {s.part, s.cfg.cmd_set_param, ({5'd0, n} + 8'd1)};
						o.tx_length = LEN_PARAM;
						o.tx_is_param = 1'b1;
						o.tx_param_part = s.part;
					end else begin
						o.tx_ext_id = {s.part, s.cfg.cmd_status_poll, ({5'd0, n} + 8'd1)};
						o.tx_length = LEN_POLL;
					end
					if (s.final_frm) begin
						s.wait_cnt = s.cfg.reply_timeout;
						s.ph = PH_WAIT;
					end else begin
						s.part = s.part + 3'd1;
						s.ph = PH_LOAD;
					end
				end
				PH_TIMEOUT: begin
					if (s.retries > 8'd1) begin
						s.retries = s.retries - 8'd1;
						if (s.final_frm)
							s.part = '0;
						s.ph = PH_LOAD;
					end else begin
						if (s.fails[n] < FAIL_LIMIT)
							s.fails[n] = s.fails[n] + 2'd1;
						else
							s.flags[n] = 1'b1;
						advance = 1'b1;
					end
				end
				PH_PARSE: begin
					s.fails[n] = '0;
					if (s.sending)
						s.data_req[n] = 1'b0;
					advance = 1'b1;
				end
				default: s.ph = PH_INIT;
				endcase
				if (advance) begin
					s.node = (s.node == 3'(NODES - 1)) ? 3'd0 : s.node + 3'd1;
					s.part = '0;
					s.retries = s.cfg.max_retries;
					s.ph = PH_LOAD;
				end
			end
		end
		o.node_fail_mask = s.flags;
	endfunction

	function automatic void add_item(req_t r);
		rsp_t scratch;
		poll_step(plan_st, r, scratch);
		req_backlog.push_back(r);
		queued++;
	endfunction

	function automatic void frame(logic [6:0] prt, logic [7:0] code, logic [7:0] ads,
			logic [7:0] d0);
		add_item({CMD_FRAME, prt, code, ads, d0});
	endfunction

	function automatic void tick();
		add_item({CMD_TICK, 23'($urandom), 8'($urandom)});
	endfunction

	// mostly ticks, well-formed replies while the plan copy waits, some noise frames
	function automatic void queue_traffic(int count, int reply_pct);
		int         start;
		int         first;
		int         skip;
		logic [1:0] p;
		logic [7:0] ads;
		start = queued;
		while (queued - start < count) begin
			if (plan_st.ph == PH_WAIT && plan_st.rflag != RF_DONE &&
					$urandom_range(0, 99) < reply_pct) begin
				ads = {5'd0, plan_st.node} + 8'd1;
				if ($urandom_range(0, 7) == 0)
					ads = 8'($urandom_range(1, NODES));
				if (plan_st.sending) begin
					frame(7'($urandom), plan_st.cfg.cmd_set_param_ack, ads, 8'($urandom));
				end else begin
					first = $urandom_range(0, 3);
					skip = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 4;
					for (int k = 0; k < 4; k++) begin
						p = 2'(first + k);
						if (k != skip) begin
							if (p == 2'd2)
								frame({5'd0, p}, plan_st.cfg.cmd_status_ack, ads,
									($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 255))
									: 8'd0);
							else
								frame({5'd0, p}, plan_st.cfg.cmd_status_ack, ads,
									8'($urandom));
						end
					end
				end
			end else if ($urandom_range(0, 9) == 0) begin
				case ($urandom_range(0, 3))
				0: add_item({CMD_FRAME, 23'($urandom), 8'($urandom)});
				1: add_item({CMD_FRAME, CFG_OFF_ID, 8'($urandom)});
				default: frame($urandom_range(0, 1) ? 7'($urandom_range(0, 3)) : 7'($urandom),
					$urandom_range(0, 1) ? plan_st.cfg.cmd_set_param_ack
					: plan_st.cfg.cmd_status_ack,
					8'($urandom_range(0, 9)), 8'($urandom));
				endcase
			end else begin
				tick();
			end
		end
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [7:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		REG_CMD_SET_PARAM:     pred_st.cfg.cmd_set_param = val;
		REG_CMD_SET_PARAM_ACK: pred_st.cfg.cmd_set_param_ack = val;
		REG_CMD_STATUS_POLL:   pred_st.cfg.cmd_status_poll = val;
		REG_CMD_STATUS_ACK:    pred_st.cfg.cmd_status_ack = val;
		REG_TICK_PRESCALE:     pred_st.cfg.tick_prescale = val;
		REG_MAX_RETRIES:       pred_st.cfg.max_retries = val;
		REG_REPLY_TIMEOUT:     pred_st.cfg.reply_timeout = val;
		default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		while (req_backlog.size() != 0 || req_valid || frame_expect.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input cfg_t c, input int count, input int reply_pct);
		drain();
		write_reg(REG_CMD_SET_PARAM, c.cmd_set_param);
		write_reg(REG_CMD_SET_PARAM_ACK, c.cmd_set_param_ack);
		write_reg(REG_CMD_STATUS_POLL, c.cmd_status_poll);
		write_reg(REG_CMD_STATUS_ACK, c.cmd_status_ack);
		write_reg(REG_TICK_PRESCALE, c.tick_prescale);
		write_reg(REG_MAX_RETRIES, c.max_retries);
		write_reg(REG_REPLY_TIMEOUT, c.reply_timeout);
		plan_st = pred_st;
		queue_traffic(count, reply_pct);
	endtask

	// request driver
	always @(negedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_took) begin
			if (req_gap != 0) begin
				req_gap <= req_gap - 1;
				req_valid <= 1'b0;
			end else if (req_backlog.size() != 0) begin
				req_valid <= 1'b1;
				req_data <= req_backlog.pop_front();
				if (!calm && $urandom_range(0, 7) == 0)
					req_gap <= $urandom_range(1, 10);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// result backpressure
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else if (rsp_stall != 0) begin
			rsp_ready <= 1'b0;
			rsp_stall <= rsp_stall - 1;
		end else begin
			rsp_ready <= 1'b1;
			if (!calm && $urandom_range(0, 9) == 0)
				rsp_stall <= $urandom_range(1, 10);
		end
	end

	// monitor and checker
	always @(posedge clk) begin
		if (arst_n) begin
			req_took <= req_valid && req_ready;
			if (req_valid && req_ready) begin
				poll_step(pred_st, req_data, want);
				frame_expect.push_back(want);
			end
			if (rsp_valid && rsp_ready) begin
				if (frame_expect.size() == 0) begin
					errors++;
					if (shown < 10) begin
						shown++;
						$display("unexpected result id %05h", rsp_data.tx_ext_id);
					end
				end else begin
					want = frame_expect.pop_front();
					if (rsp_data.tx_valid !== want.tx_valid ||
							rsp_data.tx_ext_id !== want.tx_ext_id ||
							rsp_data.tx_length !== want.tx_length ||
							rsp_data.tx_is_param !== want.tx_is_param ||
							rsp_data.tx_param_part !== want.tx_param_part ||
							rsp_data.node_fail_mask !== want.node_fail_mask) begin
						errors++;
						if (shown < 10) begin
							shown++;
							$display("mismatch: want v%0d id %05h len %0d prm %0d part %0d fail %02h",
								want.tx_valid, want.tx_ext_id, want.tx_length,
								want.tx_is_param, want.tx_param_part, want.node_fail_mask);
							$display("          got  v%0d id %05h len %0d prm %0d part %0d fail %02h",
								rsp_data.tx_valid, rsp_data.tx_ext_id, rsp_data.tx_length,
								rsp_data.tx_is_param, rsp_data.tx_param_part,
								rsp_data.node_fail_mask);
						end
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		cfg_t c;
		arst_n = 1'b0;
		calm = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		rsp_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_CMD_SET_PARAM;
		cfg_data = '0;
		pred_st = '0;
		pred_st.cfg = {8'd1, 8'd2, 8'd3, 8'd4, 8'd1, 8'd3, 8'd200};
		plan_st = pred_st;

		// directed opening with reset codes
		tick();
		frame(7'd0, 8'd2, 8'd1, 8'd0);
		tick();
		tick();
		add_item({CMD_FRAME, CFG_OFF_ID, 8'hFF});
		frame(7'd2, 8'd4, 8'd0, 8'hFF);
		frame(7'd2, 8'd4, 8'd9, 8'hFF);
		frame(7'd0, 8'h77, 8'd1, 8'd0);
		frame(7'd7, 8'd4, 8'd1, 8'd0);
		frame(7'h7F, 8'd4, 8'd8, 8'd0);
		frame(7'd2, 8'd4, 8'd1, 8'hFF);
		frame(7'd0, 8'd4, 8'd1, 8'd0);
		frame(7'd1, 8'd4, 8'd1, 8'd0);
		frame(7'd3, 8'd4, 8'd1, 8'd0);
		tick();
		tick();
		tick();
		tick();
		frame(7'd0, 8'd2, 8'd8, 8'd0);
		tick();
		tick();
		queue_traffic(110, 70);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		run_phase({8'h10, 8'h20, 8'h30, 8'h40, 8'd1, 8'd2, 8'd3}, 200, 60);
		run_phase({8'h00, 8'h55, 8'hFF, 8'h55, 8'd0, 8'd0, 8'd0}, 150, 50);
		run_phase({8'hFF, 8'h00, 8'h00, 8'hFF, 8'd2, 8'd255, 8'd255}, 150, 80);
		run_phase({8'hA5, 8'h5A, 8'hC3, 8'h3C, 8'd255, 8'd1, 8'd1}, 40, 30);
		run_phase({8'h01, 8'h02, 8'h03, 8'h04, 8'd1, 8'd1, 8'd1}, 150, 0);

		drain();
		calm = 1'b1;
		c.cmd_set_param = 8'($urandom);
		c.cmd_set_param_ack = 8'($urandom);
		c.cmd_status_poll = 8'($urandom);
		c.cmd_status_ack = 8'($urandom);
		c.tick_prescale = 8'($urandom_range(1, 3));
		c.max_retries = 8'($urandom_range(1, 4));
		c.reply_timeout = 8'($urandom_range(1, 6));
		run_phase(c, 150, 50);

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- files.f -----
src/bnpm_pkg.sv
src/bnpm_cfg_regs.sv
src/bnpm_ctrl.sv
src/bnpm_out_reg.sv
src/bus_node_poll_master_unit.sv
src/bnpm_checker.sv
dv/bus_node_poll_master_unit_tb.sv
